/* rtl/core/pe_pkg.sv */
// shared types and constants of the polynomial evaluator
package pe_pkg;

    localparam int COEF_COUNT    = 7;
    localparam int MAX_ORDER_DEF = 6;
    localparam int FRAC_SHIFT    = 12;
    localparam int ORDER_W       = 3;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 32;
    localparam int ACC_W         = 32;
    localparam int POINT_W       = 16;
    localparam int PROD_W        = ACC_W + POINT_W;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF0 = 4'd1;

    typedef struct packed {
        logic signed [ACC_W-1:0]   acc;
        logic signed [POINT_W-1:0] x;
        logic                      ovf;
    } t_item;

endpackage

/* rtl/core/pe_cell.sv */
// one horner step cell: multiply stage, then round, saturate and add stage
module pe_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_active,
    input  logic signed [31:0] i_coef,
    input  logic               i_valid,
    output logic               o_ready,
    input  pe_pkg::t_item      i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output pe_pkg::t_item      o_item
);
    import pe_pkg::*;

    logic                     r_v1;
    logic signed [PROD_W-1:0] r_prod;
    t_item                    r_item1;
    logic                     r_v2;
    t_item                    r_item2;

    logic adv1;
    logic adv2;

    logic signed [PROD_W:0]              rnd_sum;
    logic signed [PROD_W-FRAC_SHIFT:0]   scaled;
    logic signed [ACC_W-1:0]             scaled_sat;
    logic                                ovf_mul;
    logic signed [ACC_W:0]               add_sum;
    logic signed [ACC_W-1:0]             add_sat;
    logic                                ovf_add;
    t_item                               n_item2;

    assign adv2    = !r_v2 || i_ready;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;
    assign o_valid = r_v2;
    assign o_item  = r_item2;

    always_comb begin
        // round half up: add half an lsb, then floor shift
        rnd_sum = {r_prod[PROD_W-1], r_prod} + (PROD_W+1)'(1 << (FRAC_SHIFT - 1));
        scaled  = rnd_sum[PROD_W:FRAC_SHIFT];
        ovf_mul = (scaled[PROD_W-FRAC_SHIFT:ACC_W-1] != '0) &&
                  (scaled[PROD_W-FRAC_SHIFT:ACC_W-1] != '1);
        if (ovf_mul) begin
            scaled_sat = scaled[PROD_W-FRAC_SHIFT] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                   : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            scaled_sat = scaled[ACC_W-1:0];
        end
        add_sum = {scaled_sat[ACC_W-1], scaled_sat} + {i_coef[ACC_W-1], i_coef};
        ovf_add = add_sum[ACC_W] != add_sum[ACC_W-1];
        if (ovf_add) begin
            add_sat = add_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                     : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            add_sat = add_sum[ACC_W-1:0];
        end
        n_item2 = r_item1;
        if (i_active) begin
            n_item2.acc = add_sat;
            n_item2.ovf = r_item1.ovf | ovf_mul | ovf_add;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) begin
            r_prod  <= i_item.acc * i_item.x;
            r_item1 <= i_item;
        end
        if (adv2 && r_v1) begin
            r_item2 <= n_item2;
        end
    end

endmodule

/* rtl/core/polynomial_evaluator.sv */
// top level of the fixed point horner polynomial evaluator
// Evaluates the configured polynomial at each point x (signed Q3.12) and returns
// one saturated Q15.16 value with an overflow flag per point. A chain of
// MAX_ORDER horner cells, each a multiply stage followed by a round, saturate
// and add stage, takes one point per cycle while the output is not stalled.
// Lower orders pass through the leading cells unchanged, so the path does not
// depend on the configured order. Each stage holds its own transaction and
// fills bubbles while the output is stalled. The user must write configuration
// through i_cfg_we/i_cfg_idx/i_cfg_data only while idle; unchecked by the block.
module polynomial_evaluator #(
    parameter int MAX_ORDER = pe_pkg::MAX_ORDER_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [15:0]            i_point,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [31:0]            o_poly_value,
    output logic                          o_overflow
);
    import pe_pkg::*;

    localparam int NCELL   = MAX_ORDER;
    localparam int ORD_LIM = (MAX_ORDER < COEF_COUNT - 1) ? MAX_ORDER : COEF_COUNT - 1;

    logic [ORDER_W-1:0]      r_order;
    logic signed [ACC_W-1:0] r_coef [COEF_COUNT];

    logic [ORDER_W-1:0]   order_eff;
    logic [ORDER_W-1:0]   coef_sel;
    t_item                s_item  [NCELL+1];
    logic                 s_valid [NCELL+1];
    logic                 s_ready [NCELL+1];

    assign coef_sel = ORDER_W'(i_cfg_idx - REG_COEF0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= '0;
            for (int i = 0; i < COEF_COUNT; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_ORDER) begin
                r_order <= i_cfg_data[ORDER_W-1:0];
            end else if (i_cfg_idx >= REG_COEF0 &&
                         i_cfg_idx < REG_COEF0 + CFG_IDX_W'(COEF_COUNT)) begin
                r_coef[coef_sel] <= i_cfg_data[ACC_W-1:0];
            end
        end
    end

    always_comb begin
        order_eff = (r_order > ORDER_W'(ORD_LIM)) ? ORDER_W'(ORD_LIM) : r_order;
        s_item[0].acc = r_coef[order_eff];
        s_item[0].x   = i_point;
        s_item[0].ovf = 1'b0;
    end

    assign s_valid[0]     = i_in_valid;
    assign o_in_ready     = s_ready[0];
    assign s_ready[NCELL] = i_out_ready;
    assign o_out_valid    = s_valid[NCELL];
    assign o_poly_value   = s_item[NCELL].acc;
    assign o_overflow     = s_item[NCELL].ovf;

    // cell j handles coefficient index NCELL-1-j
    for (genvar j = 0; j < NCELL; j++) begin : g_cell
        localparam int K = NCELL - 1 - j;
        pe_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_active (ORDER_W'(K) < order_eff),
            .i_coef   (r_coef[K]),
            .i_valid  (s_valid[j]),
            .o_ready  (s_ready[j]),
            .i_item   (s_item[j]),
            .o_valid  (s_valid[j+1]),
            .i_ready  (s_ready[j+1]),
            .o_item   (s_item[j+1])
        );
    end

endmodule

/* rtl/core/pe_checker.sv */
// port level checks of the polynomial evaluator and their bind
module pe_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_poly_value,
    input logic               o_overflow
);

    // a pending result transaction is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result valid dropped before transaction");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_poly_value) && $stable(o_overflow))
        else $error("stalled result changed");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // with nothing waiting at the output every stage can take data
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

endmodule

bind polynomial_evaluator pe_checker u_pe_checker (.*);

/* verif/tb_polynomial_evaluator.sv */
// self-checking testbench of the horner polynomial evaluator
`timescale 1ns / 100ps

module tb_polynomial_evaluator;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYC   = 9;
    localparam int MAX_ORDER   = pe_pkg::MAX_ORDER_DEF;
    localparam int LATENCY     = 2 * MAX_ORDER;
    localparam int ITEM_TARGET = 1650;
    localparam int REPORT_MAX  = 10;
    localparam int REG_LAST    = pe_pkg::REG_COEF0 + pe_pkg::COEF_COUNT - 1;

    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;
    localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] C_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] C_MIN  = 32'sh8000_0000;

    typedef struct {
        logic signed [31:0] value;
        logic               ovf;
    } t_poly_expect;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [pe_pkg::CFG_IDX_W-1:0]    cfg_idx;
    logic [pe_pkg::CFG_DATA_W-1:0]   cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    logic signed [15:0]              point;
    logic                            out_valid;
    logic                            out_ready;
    logic signed [31:0]              poly_value;
    logic                            overflow;

    // shadow copy of the configuration registers
    logic [pe_pkg::ORDER_W-1:0]      order_sh;
    logic signed [31:0]              coef_sh [pe_pkg::COEF_COUNT];

    logic signed [15:0]              pending_points [$];
    t_poly_expect                    expected_values [$];

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int points_sent;
    int results_seen;
    int ovf_seen;
    int poly_sets;

    polynomial_evaluator dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_point      (point),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_poly_value (poly_value),
        .o_overflow   (overflow)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v,
                                                   output logic hit);
        hit = 1'b0;
        if (v > SAT_HI) begin
            hit = 1'b1;
            return SAT_HI;
        end
        if (v < SAT_LO) begin
            hit = 1'b1;
            return SAT_LO;
        end
        return v;
    endfunction

    // horner evaluation with round half up and saturation at every step
    function automatic t_poly_expect horner_eval(input logic signed [15:0] x);
        t_poly_expect       r;
        int                 top;
        logic signed [63:0] acc;
        logic signed [63:0] prod;
        logic signed [63:0] scaled;
        logic               hit;
        top = (int'(order_sh) > MAX_ORDER) ? MAX_ORDER : int'(order_sh);
        r.ovf = 1'b0;
        acc = coef_sh[top];
        for (int k = top - 1; k >= 0; k--) begin
            prod   = acc * x;
            // arithmetic shift of a signed value is a floor division
            scaled = clamp32((prod + 64'sd2048) >>> pe_pkg::FRAC_SHIFT, hit);
            r.ovf  = r.ovf | hit;
            acc    = clamp32(scaled + coef_sh[k], hit);
            r.ovf  = r.ovf | hit;
        end
        r.value = acc[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] pick_coef();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return int'($urandom_range(0, 1 << 18)) - (1 << 17);
        if (sel < 70)
            return int'($urandom_range(0, 1 << 25)) - (1 << 24);
        if (sel < 90)
            return $urandom();
        case ($urandom_range(3))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return 32'sd0;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic logic signed [15:0] pick_point();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return 16'($urandom());
        if (sel < 85)
            return 16'(int'($urandom_range(0, 8192)) - 4096);
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sd0;
            3:       return -16'sd1;
            4:       return 16'sd1;
            5:       return 16'sd4096;
            6:       return -16'sd4096;
            default: return 16'sd2048;
        endcase
    endfunction

    // register file mirror, updated at the same edge as the block
    always @(posedge clk) begin
        if (!rst_n) begin
            order_sh <= '0;
            for (int k = 0; k < pe_pkg::COEF_COUNT; k++)
                coef_sh[k] <= '0;
        end else if (cfg_we) begin
            if (cfg_idx == pe_pkg::REG_ORDER)
                order_sh <= cfg_data[pe_pkg::ORDER_W-1:0];
            else if (int'(cfg_idx) <= REG_LAST)
                coef_sh[pe_pkg::ORDER_W'(cfg_idx - pe_pkg::REG_COEF0)] <= cfg_data;
        end
    end

    // driver: feeds pending points and predicts each accepted transaction
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_values.push_back(horner_eval(point));
                points_sent++;
            end
            if (!in_valid || in_ready) begin
                if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    point    <= pending_points.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: compares every result transaction with the oldest prediction
    always @(posedge clk) begin : result_check
        t_poly_expect want;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (overflow === 1'b1)
                ovf_seen++;
            if (expected_values.size() == 0) begin
                if (error_count < REPORT_MAX)
                    $display("unexpected result value=%0d ovf=%b", poly_value, overflow);
                error_count++;
            end else begin
                want = expected_values.pop_front();
                if (poly_value !== want.value || overflow !== want.ovf) begin
                    if (error_count < REPORT_MAX)
                        $display("mismatch: expected value=%0d ovf=%b, got value=%0d ovf=%b",
                                 want.value, want.ovf, poly_value, overflow);
                    error_count++;
                end
            end
        end
    end

    task automatic write_reg(input logic [pe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pe_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        poly_sets++;
    endtask

    task automatic wait_idle();
        while (pending_points.size() != 0 || in_valid || expected_values.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_idling(input int done);
        if (done < ITEM_TARGET / 3) begin
            send_idle_pct = 10;
            recv_idle_pct = 86;
        end else if (done < 2 * ITEM_TARGET / 3) begin
            send_idle_pct = 86;
            recv_idle_pct = 10;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    initial begin : stimulus
        int                              seg_len;
        logic [pe_pkg::CFG_IDX_W-1:0]    idx;
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        point         = '0;
        out_ready     = 1'b0;
        error_count   = 0;
        points_sent   = 0;
        results_seen  = 0;
        ovf_seen      = 0;
        poly_sets     = 0;
        set_idling(0);
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // all-zero polynomial straight out of reset
        pending_points.push_back(16'sh8000);
        pending_points.push_back(16'sh7FFF);
        pending_points.push_back(16'sd0);
        wait_idle();

        // order zero returns the constant term untouched
        write_reg(pe_pkg::REG_COEF0, C_MIN);
        end_writes();
        pending_points.push_back(-16'sd1);
        pending_points.push_back(16'sd12345);
        wait_idle();

        // order code 7 clamps to six; writes past the last register are dropped
        write_reg(pe_pkg::REG_ORDER, 32'hFFFF_FFFF);
        for (int k = 0; k < pe_pkg::COEF_COUNT; k++)
            write_reg(pe_pkg::CFG_IDX_W'(pe_pkg::REG_COEF0 + k), Q_ONE);
        for (int k = REG_LAST + 1; k < (1 << pe_pkg::CFG_IDX_W); k++) begin
            idx = pe_pkg::CFG_IDX_W'(k);
            write_reg(idx, $urandom());
        end
        end_writes();
        pending_points.push_back(16'sd4096);
        pending_points.push_back(-16'sd4096);
        pending_points.push_back(16'sd0);
        pending_points.push_back(16'sd2048);
        wait_idle();

        // largest coefficients at the extremes of x saturate
        write_reg(pe_pkg::REG_ORDER, MAX_ORDER);
        for (int k = 0; k < pe_pkg::COEF_COUNT; k++)
            write_reg(pe_pkg::CFG_IDX_W'(pe_pkg::REG_COEF0 + k), C_MAX);
        end_writes();
        pending_points.push_back(16'sh7FFF);
        pending_points.push_back(16'sh8000);
        pending_points.push_back(16'sd1);
        wait_idle();

        // most negative linear term, then ties of the rounding step
        write_reg(pe_pkg::REG_ORDER, 1);
        write_reg(pe_pkg::REG_COEF0, C_MIN);
        write_reg(pe_pkg::CFG_IDX_W'(pe_pkg::REG_COEF0 + 1), C_MIN);
        end_writes();
        pending_points.push_back(16'sh8000);
        pending_points.push_back(16'sh7FFF);
        pending_points.push_back(16'sd1);
        wait_idle();
        write_reg(pe_pkg::REG_COEF0, 32'sd0);
        write_reg(pe_pkg::CFG_IDX_W'(pe_pkg::REG_COEF0 + 1), 32'sd3);
        end_writes();
        pending_points.push_back(16'sd2048);
        pending_points.push_back(-16'sd2048);
        pending_points.push_back(-16'sd6144);
        wait_idle();

        // random coefficient sets, each followed by a burst of points
        while (points_sent < ITEM_TARGET) begin
            set_idling(points_sent);
            write_reg(pe_pkg::REG_ORDER, $urandom_range(0, (1 << pe_pkg::ORDER_W) - 1));
            for (int k = 0; k < pe_pkg::COEF_COUNT; k++)
                write_reg(pe_pkg::CFG_IDX_W'(pe_pkg::REG_COEF0 + k), pick_coef());
            if ($urandom_range(9) == 0) begin
                idx = pe_pkg::CFG_IDX_W'($urandom_range(REG_LAST + 1,
                                                        (1 << pe_pkg::CFG_IDX_W) - 1));
                write_reg(idx, $urandom());
            end
            end_writes();
            seg_len = $urandom_range(20, 60);
            for (int n = 0; n < seg_len; n++)
                pending_points.push_back(pick_point());
            wait_idle();
        end

        repeat (LATENCY + 8) @(posedge clk);
        $display("evaluated %0d points over %0d coefficient sets", points_sent, poly_sets);
        $display("checked %0d results, %0d of them saturated", results_seen, ovf_seen);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d failures", error_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("timeout");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
rtl/core/pe_pkg.sv
rtl/core/pe_cell.sv
rtl/core/polynomial_evaluator.sv
rtl/core/pe_checker.sv
verif/tb_polynomial_evaluator.sv
